@@ design/hkq_pkg.sv @@
// Package: shared widths, defaults and the event entry type for the key-change queue.
`timescale 1ns / 1ps

package hkq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;

    localparam int HELD_W  = 16;
    localparam int INDEX_W = 4;

    typedef struct packed {
        logic               pressed;
        logic [INDEX_W-1:0] index;
    } t_event;

    localparam int ENTRY_W = $bits(t_event);

endpackage

@@ design/hkq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module hkq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/held_key_change_event_queue.sv @@
// Top level: held-key change detector feeding a press/release event FIFO.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one item: i_opcode and i_held_mask,
//   a mask of the keys held down now. The block compares the low KEY_BITS bits
//   with the mask it kept and queues one press or release event per changed
//   bit, lowest bit first, into a QUEUE_DEPTH-entry FIFO. Events that find the
//   FIFO full are dropped. An opcode 0 item gives no result; an opcode 1 item
//   then pops one event and returns it on the output channel (o_valid /
//   i_ready) with o_event_valid = 0 when the FIFO was empty.
// Scan and pop:
//   The change scan walks the changed bits one per cycle, lowest first, and
//   stops after the highest changed bit. A pop reads the RAM into its
//   registered read port, then loads the output register; the next item can
//   be accepted once that load is done and the block is back in idle.
// Reset: the kept mask and the FIFO pointers clear; FIFO contents are not
//   cleared, and no clearing pass is needed.
// Stall: a result waits in the output register while i_ready is low; the next
//   item is still accepted, scanned and popped; only its result waits for room.
`timescale 1ns / 1ps

module held_key_change_event_queue #(
    parameter int QUEUE_DEPTH = hkq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = hkq_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_opcode,
    input  logic [hkq_pkg::HELD_W-1:0]  i_held_mask,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_event_valid,
    output logic                        o_key_pressed,
    output logic [hkq_pkg::INDEX_W-1:0] o_key_index
);

    import hkq_pkg::*;

    localparam int ADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int BIT_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int HELD_EXT_W = (KEY_BITS > HELD_W) ? KEY_BITS : HELD_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_RESP
    } t_state;

    t_state              r_state, n_state;
    logic [KEY_BITS-1:0] r_prev_mask, n_prev_mask;
    logic [KEY_BITS-1:0] r_chg, n_chg;     // changed bits, shifted out LSB first
    logic [KEY_BITS-1:0] r_now, n_now;     // new mask, shifted in step with r_chg
    logic [BIT_W-1:0]    r_bit, n_bit;     // key index of r_chg[0]
    logic                r_op, n_op;
    logic                r_hit, n_hit;     // pop found an event
    logic [ADDR_W-1:0]   r_wr_addr, n_wr_addr;
    logic                r_wr_lap, n_wr_lap;
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic                r_rd_lap, n_rd_lap;
    logic                r_out_valid, n_out_valid;
    logic                r_out_ev, n_out_ev;   // event flag of the held result
    t_event              r_out, n_out;

    logic [HELD_EXT_W-1:0] w_held_ext;
    logic [KEY_BITS-1:0]   w_now;
    logic [KEY_BITS-1:0]   w_changed;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_push;
    logic                  w_pop;
    t_event                w_push_entry;
    t_event                w_rd_entry;
    logic [ENTRY_W-1:0]    w_rd_data;

    assign w_held_ext = HELD_EXT_W'(i_held_mask);
    assign w_now      = w_held_ext[KEY_BITS-1:0];
    assign w_changed  = w_now ^ r_prev_mask;
    assign w_accept   = i_valid && o_ready;

    assign w_full  = (r_wr_addr == r_rd_addr) && (r_wr_lap != r_rd_lap);
    assign w_empty = (r_wr_addr == r_rd_addr) && (r_wr_lap == r_rd_lap);

    // Push the event for the bit at the bottom of the scan; drop it when full.
    assign w_push               = (r_state == S_SCAN) && r_chg[0] && !w_full;
    assign w_push_entry.pressed = r_now[0];
    assign w_push_entry.index   = INDEX_W'(r_bit);

    assign w_pop = (r_state == S_POP) && !w_empty;

    hkq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_push),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (w_push_entry),
        .i_rd_en   (w_pop),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_entry = w_rd_data;

    always_comb begin
        n_state     = r_state;
        n_prev_mask = r_prev_mask;
        n_chg       = r_chg;
        n_now       = r_now;
        n_bit       = r_bit;
        n_op        = r_op;
        n_hit       = r_hit;
        n_wr_addr   = r_wr_addr;
        n_wr_lap    = r_wr_lap;
        n_rd_addr   = r_rd_addr;
        n_rd_lap    = r_rd_lap;
        n_out_valid = r_out_valid;
        n_out_ev    = r_out_ev;
        n_out       = r_out;

        // Release the output register once the receiver takes the item.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_opcode;
                    n_chg = w_changed;
                    n_now = w_now;
                    n_bit = '0;
                    if (|w_changed) begin
                        // Keep the new mask only when something changed.
                        n_prev_mask = w_now;
                        n_state     = S_SCAN;
                    end else if (i_opcode) begin
                        n_state = S_POP;
                    end
                end
            end
            S_SCAN: begin
                if (w_push) begin
                    if (r_wr_addr == LAST_ADDR) begin
                        n_wr_addr = '0;
                        n_wr_lap  = !r_wr_lap;
                    end else begin
                        n_wr_addr = r_wr_addr + 1'b1;
                    end
                end
                n_chg = r_chg >> 1;
                n_now = r_now >> 1;
                n_bit = r_bit + 1'b1;
                // Stop as soon as no changed bit is left above.
                if (!(|n_chg)) begin
                    n_state = r_op ? S_POP : S_IDLE;
                end
            end
            S_POP: begin
                n_hit = !w_empty;
                if (w_pop) begin
                    if (r_rd_addr == LAST_ADDR) begin
                        n_rd_addr = '0;
                        n_rd_lap  = !r_rd_lap;
                    end else begin
                        n_rd_addr = r_rd_addr + 1'b1;
                    end
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                // Hold the read data until the output register has room.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ev    = r_hit;
                    n_out       = r_hit ? w_rd_entry : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_mask <= '0;
            r_wr_addr   <= '0;
            r_wr_lap    <= 1'b0;
            r_rd_addr   <= '0;
            r_rd_lap    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev_mask <= n_prev_mask;
            r_wr_addr   <= n_wr_addr;
            r_wr_lap    <= n_wr_lap;
            r_rd_addr   <= n_rd_addr;
            r_rd_lap    <= n_rd_lap;
            r_out_valid <= n_out_valid;
        end
        r_chg    <= n_chg;
        r_now    <= n_now;
        r_bit    <= n_bit;
        r_op     <= n_op;
        r_hit    <= n_hit;
        r_out_ev <= n_out_ev;
        r_out    <= n_out;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_event_valid = r_out_valid && r_out_ev;
    assign o_key_pressed = r_out.pressed;
    assign o_key_index   = r_out.index;

    // An empty pop returns all-zero event fields.
    a_empty_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_event_valid) |-> (!o_key_pressed && (o_key_index == '0)))
        else $error("empty pop returned nonzero event fields");

    // A scan never runs with no changed bit left.
    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_chg != '0))
        else $error("scan state with no changed bits");

    // A poll-only item that changes nothing finishes at once.
    a_quiet_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_opcode && (w_changed == '0)) |=> o_ready)
        else $error("quiet poll-only item did not return to ready");

    // A popped event leaves the FIFO one entry lighter: read pointer moved.
    a_pop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_rd_addr != $past(r_rd_addr)) || (r_rd_lap != $past(r_rd_lap)))
        else $error("pop did not advance the read pointer");

endmodule
